### sv/pbclk_pkg.sv
// Shared types, constants and saturation helpers for the playback clock.
package pbclk_pkg;

    localparam int TRIG_SLOTS = 16;
    localparam int TRIG_IDX_W = (TRIG_SLOTS > 1) ? $clog2(TRIG_SLOTS) : 1;
    localparam int TRIG_CNT_W = $clog2(TRIG_SLOTS + 1);

    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int PADDR_W   = 5;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_SEEK    = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_WRITE   = 2'd3
    } kind_t;

    localparam logic RES_TRIGGER = 1'b0;
    localparam logic RES_REPORT  = 1'b1;

    localparam logic [2:0] REG_CLIP_LENGTH   = 3'd0;
    localparam logic [2:0] REG_SPEED         = 3'd1;
    localparam logic [2:0] REG_LOOP_MODE     = 3'd2;
    localparam logic [2:0] REG_INVERSE_MODE  = 3'd3;
    localparam logic [2:0] REG_ENABLED       = 3'd4;
    localparam logic [2:0] REG_TRIGGER_COUNT = 3'd5;

    typedef struct packed {
        logic [30:0]        clip_length;
        logic signed [15:0] speed;
        logic               loop_mode;
        logic               inverse_mode;
        logic               enabled;
        logic [4:0]         trigger_count;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic wr_entry;
        logic mul;
        logic dt;
        logic step;
        logic seek;
        logic restart;
        logic scan;
        logic walk_emit;
        logic report;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  enabled;
        logic  wrap;
        logic  scan_done;
        logic  walk_fire;
        logic  out_free;
    } dp_sts_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
        if (v[39:31] != {9{v[39]}}) begin
            return v[39] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

endpackage

### sv/pbclk_regs.sv
// APB configuration registers of the playback clock.
module pbclk_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pbclk_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output pbclk_pkg::cfg_t                cfg
);
    import pbclk_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.clip_length   <= 31'd65536;
            cfg_reg.speed         <= 16'sd256;
            cfg_reg.loop_mode     <= 1'b1;
            cfg_reg.inverse_mode  <= 1'b0;
            cfg_reg.enabled       <= 1'b1;
            cfg_reg.trigger_count <= 5'd0;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_CLIP_LENGTH:   cfg_reg.clip_length   <= pwdata[30:0];
                REG_SPEED:         cfg_reg.speed         <= pwdata[15:0];
                REG_LOOP_MODE:     cfg_reg.loop_mode     <= pwdata[0];
                REG_INVERSE_MODE:  cfg_reg.inverse_mode  <= pwdata[0];
                REG_ENABLED:       cfg_reg.enabled       <= pwdata[0];
                REG_TRIGGER_COUNT: cfg_reg.trigger_count <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_CLIP_LENGTH:   prdata = {1'b0, cfg_reg.clip_length};
            REG_SPEED:         prdata = {16'd0, cfg_reg.speed};
            REG_LOOP_MODE:     prdata = {31'd0, cfg_reg.loop_mode};
            REG_INVERSE_MODE:  prdata = {31'd0, cfg_reg.inverse_mode};
            REG_ENABLED:       prdata = {31'd0, cfg_reg.enabled};
            REG_TRIGGER_COUNT: prdata = {27'd0, cfg_reg.trigger_count};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

### sv/pbclk_ctrl.sv
// Sequencing state machine of the playback clock.
module pbclk_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  pbclk_pkg::dp_sts_t  sts,
    output pbclk_pkg::dp_cmd_t  cmd
);
    import pbclk_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_MUL     = 9'b000000010,
        ST_DT      = 9'b000000100,
        ST_STEP    = 9'b000001000,
        ST_SCAN    = 9'b000010000,
        ST_RESTART = 9'b000100000,
        ST_SEEK    = 9'b001000000,
        ST_WALK    = 9'b010000000,
        ST_REPORT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   stepped_reg, stepped_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            stepped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            stepped_reg <= stepped_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        stepped_next = stepped_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture  = 1'b1;
                    stepped_next = 1'b0;
                    case (sts.kind)
                        KIND_TICK:    state_next = sts.enabled ? ST_MUL : ST_REPORT;
                        KIND_SEEK:    state_next = ST_SEEK;
                        KIND_RESTART: state_next = ST_RESTART;
                        KIND_WRITE: begin
                            cmd.wr_entry = 1'b1;
                            state_next   = ST_REPORT;
                        end
                        default:      state_next = ST_REPORT;
                    endcase
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DT;
            end
            ST_DT: begin
                cmd.dt     = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.step     = 1'b1;
                stepped_next = 1'b1;
                state_next   = sts.wrap ? ST_SCAN : ST_WALK;
            end
            ST_RESTART: begin
                cmd.restart = 1'b1;
                state_next  = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    if (stepped_reg) begin
                        state_next = ST_WALK;
                    end else begin
                        state_next = sts.enabled ? ST_MUL : ST_REPORT;
                    end
                end
            end
            ST_SEEK: begin
                cmd.seek   = 1'b1;
                state_next = ST_REPORT;
            end
            ST_WALK: begin
                if (sts.walk_fire) begin
                    cmd.walk_emit = sts.out_free;
                end else begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (sts.out_free) begin
                    cmd.report = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### sv/pbclk_dp.sv
// Position, step arithmetic, trigger table and result register of the playback clock.
module pbclk_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  pbclk_pkg::cfg_t     cfg,
    input  pbclk_pkg::dp_cmd_t  cmd,
    output pbclk_pkg::dp_sts_t  sts,
    input  pbclk_pkg::kind_t    in_kind,
    input  logic [30:0]         in_tick,
    input  logic signed [31:0]  in_seek,
    input  logic [3:0]          in_index,
    input  logic [30:0]         in_time,
    input  logic [15:0]         in_type,
    input  logic                m_tready,
    output logic                out_valid,
    output logic                out_kind,
    output logic [15:0]         out_type,
    output logic signed [31:0]  out_time,
    output logic                out_wrapped,
    output logic                out_end,
    output logic                out_last
);
    import pbclk_pkg::*;

    logic [30:0] trig_time_mem [TRIG_SLOTS];
    logic [15:0] trig_type_mem [TRIG_SLOTS];
    logic [30:0] time_q;
    logic [15:0] type_q;

    logic signed [31:0]      pos_reg;
    logic [TRIG_IDX_W-1:0]   nt_reg, nt_next;
    logic                    ntv_reg, ntv_next;
    logic [30:0]             tick_reg;
    logic signed [31:0]      seek_reg;
    logic signed [47:0]      prod_reg;
    logic signed [31:0]      dt_reg;
    logic                    wr_reg;
    logic                    er_reg;
    logic                    out_valid_reg;

    logic [TRIG_CNT_W-1:0]   live_n;
    logic [TRIG_CNT_W-1:0]   nt_inc;
    logic [TRIG_IDX_W-1:0]   scan_start;
    logic signed [32:0]      pos33, len33, dt33, time33;
    logic                    scan_empty, scan_match, scan_end, nt_last_fwd, wrap;

    always_comb begin
        if (int'(cfg.trigger_count) > TRIG_SLOTS) begin
            live_n = TRIG_CNT_W'(TRIG_SLOTS);
        end else begin
            live_n = TRIG_CNT_W'(cfg.trigger_count);
        end
    end

    assign pos33  = {pos_reg[31], pos_reg};
    assign len33  = $signed({2'b00, cfg.clip_length});
    assign dt33   = {dt_reg[31], dt_reg};
    assign time33 = $signed({2'b00, time_q});

    assign nt_inc      = TRIG_CNT_W'(nt_reg) + TRIG_CNT_W'(1);
    assign nt_last_fwd = (nt_inc >= live_n);
    assign scan_empty  = (live_n == '0);
    assign scan_match  = cfg.inverse_mode ? (time33 < pos33) : (time33 > pos33);
    assign scan_end    = cfg.inverse_mode ? (nt_reg == '0) : nt_last_fwd;
    assign scan_start  = (cfg.inverse_mode && !scan_empty) ?
                         TRIG_IDX_W'(live_n - TRIG_CNT_W'(1)) : '0;
    assign wrap        = cfg.loop_mode && (pos_reg[31] || (pos33 >= len33));

    assign sts.kind      = in_kind;
    assign sts.enabled   = cfg.enabled;
    assign sts.wrap      = wrap;
    assign sts.scan_done = scan_empty || scan_match || scan_end;
    assign sts.walk_fire = !cfg.inverse_mode && ntv_reg && (pos33 > time33);
    assign sts.out_free  = !out_valid_reg || m_tready;

    // trigger pointer doubles as the scan index
    always_comb begin
        nt_next  = nt_reg;
        ntv_next = ntv_reg;
        if ((cmd.step && wrap) || cmd.restart) begin
            nt_next  = scan_start;
            ntv_next = 1'b0;
        end else if (cmd.scan) begin
            if (scan_empty) begin
                nt_next  = '0;
                ntv_next = 1'b0;
            end else if (scan_match) begin
                ntv_next = 1'b1;
            end else if (scan_end) begin
                nt_next  = '0;
            end else if (cfg.inverse_mode) begin
                nt_next  = nt_reg - TRIG_IDX_W'(1);
            end else begin
                nt_next  = nt_reg + TRIG_IDX_W'(1);
            end
        end else if (cmd.walk_emit) begin
            if (nt_last_fwd) begin
                nt_next  = '0;
                ntv_next = 1'b0;
            end else begin
                nt_next  = nt_reg + TRIG_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_entry && (int'(in_index) < TRIG_SLOTS)) begin
            trig_time_mem[TRIG_IDX_W'(in_index)] <= in_time;
            trig_type_mem[TRIG_IDX_W'(in_index)] <= in_type;
        end
        time_q <= trig_time_mem[nt_next];
        type_q <= trig_type_mem[nt_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            nt_reg  <= '0;
            ntv_reg <= 1'b0;
        end else begin
            nt_reg  <= nt_next;
            ntv_reg <= ntv_next;
            if (cmd.restart) begin
                pos_reg <= '0;
            end else if (cmd.seek && cfg.enabled) begin
                if (seek_reg[31]) begin
                    pos_reg <= '0;
                end else if (seek_reg[30:0] > cfg.clip_length) begin
                    pos_reg <= $signed({1'b0, cfg.clip_length});
                end else begin
                    pos_reg <= seek_reg;
                end
            end else if (cmd.step) begin
                if (cfg.loop_mode) begin
                    pos_reg <= wrap ? 32'sd0 : sat33(pos33 + dt33);
                end else if (pos_reg[31]) begin
                    pos_reg <= '0;
                end else if (pos33 > len33) begin
                    pos_reg <= sat33(len33 - dt33);
                end else begin
                    pos_reg <= sat33(pos33 + dt33);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            tick_reg <= (in_kind == KIND_TICK) ? in_tick : '0;
            seek_reg <= in_seek;
            wr_reg   <= 1'b0;
            er_reg   <= 1'b0;
        end else if (cmd.step) begin
            if (cfg.loop_mode) begin
                wr_reg <= wr_reg | wrap;
            end else begin
                er_reg <= pos_reg[31] || (pos33 > len33);
            end
        end
        if (cmd.mul) begin
            prod_reg <= $signed(cfg.speed) * $signed({1'b0, tick_reg});
        end
        if (cmd.dt) begin
            dt_reg <= sat40(prod_reg[47:8]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.walk_emit || cmd.report) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.walk_emit) begin
            out_kind    <= RES_TRIGGER;
            out_type    <= type_q;
            out_time    <= pos_reg;
            out_wrapped <= 1'b0;
            out_end     <= 1'b0;
            out_last    <= 1'b0;
        end else if (cmd.report) begin
            out_kind    <= RES_REPORT;
            out_type    <= '0;
            out_time    <= cfg.inverse_mode ? sat33(len33 - pos33) : pos_reg;
            out_wrapped <= wr_reg;
            out_end     <= er_reg;
            out_last    <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### sv/playback_clock_with_triggers.sv
// Top level of the playback position clock with trigger table.
// One item at a time. A trigger write goes to its report, a seek through a seek step, a tick through
// multiply, scale, step and trigger walk (none when disabled), a restart through the table scan
// (one entry per cycle) and a tick; a loop wrap adds the scan. Result stalls hold each trigger and report.
// Reset (aresetn low, synchronous): position and trigger pointer cleared, registers to
// defaults; the trigger table is not cleared.
module playback_clock_with_triggers (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tick_amount[30:0], seek_position[62:31], entry_index[66:63],
    // entry_time[97:67], entry_type[113:98], zero pad
    input  logic [pbclk_pkg::S_TDATA_W-1:0]      s_tdata,
    // kind[1:0]
    input  logic [pbclk_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // fired_type[15:0], sample_time[47:16], loop_wrapped[48], end_reached[49], zero pad
    output logic [pbclk_pkg::M_TDATA_W-1:0]      m_tdata,
    // result_kind[0]
    output logic [0:0]                           m_tuser,
    output logic                                 m_tlast,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pbclk_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import pbclk_pkg::*;

    cfg_t               cfg;
    dp_cmd_t            cmd;
    dp_sts_t            sts;
    logic               out_kind;
    logic [15:0]        out_type;
    logic signed [31:0] out_time;
    logic               out_wrapped;
    logic               out_end;

    pbclk_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pbclk_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pbclk_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .cmd         (cmd),
        .sts         (sts),
        .in_kind     (kind_t'(s_tuser[1:0])),
        .in_tick     (s_tdata[30:0]),
        .in_seek     ($signed(s_tdata[62:31])),
        .in_index    (s_tdata[66:63]),
        .in_time     (s_tdata[97:67]),
        .in_type     (s_tdata[113:98]),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .out_kind    (out_kind),
        .out_type    (out_type),
        .out_time    (out_time),
        .out_wrapped (out_wrapped),
        .out_end     (out_end),
        .out_last    (m_tlast)
    );

    assign m_tdata = {6'd0, out_end, out_wrapped, out_time, out_type};
    assign m_tuser = out_kind;

endmodule

### sv/pbclk_checker.sv
// Port-level checks of the playback clock, bound to the top level.
module pbclk_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [pbclk_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [0:0]                         m_tuser,
    input logic                               m_tlast
);
    import pbclk_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_last_is_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser[0] == RES_REPORT)))
        else $error("tlast does not match report kind");

    a_trigger_no_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> (m_tdata[49:48] == 2'b00))
        else $error("trigger result carries wrap or end flag");

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on two consecutive cycles");

endmodule

bind playback_clock_with_triggers pbclk_checker u_pbclk_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### bench/tb_playback_clock_with_triggers.sv
// Self-checking bench for the playback clock: directed cases, then randomized phases.
`timescale 1ns / 1ps

module tb_playback_clock_with_triggers;
    import pbclk_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int STALL_MAX  = 14;
    localparam int HANG_LIMIT = 3000;
    localparam longint INT32_HI = 64'sd2147483647;
    localparam longint INT32_LO = -64'sd2147483648;

    typedef struct {
        logic               rkind;
        logic [15:0]        ftype;
        logic signed [31:0] stime;
        logic               wrap;
        logic               endr;
        logic               is_last;
    } pb_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // predicted block state
    logic [30:0]        cfg_clip;
    logic signed [15:0] cfg_speed;
    logic               cfg_loop;
    logic               cfg_inverse;
    logic               cfg_enabled;
    logic [4:0]         cfg_count;
    logic signed [31:0] clk_pos;
    logic [3:0]         walk_idx;
    logic               walk_valid;
    logic [30:0]        entry_times [TRIG_SLOTS];
    logic [15:0]        entry_types [TRIG_SLOTS];

    pb_result_t playback_results[$];
    int         error_count = 0;
    int         hang_cycles = 0;
    int         idle_pct    = 0;
    bit         quiet_tail  = 1'b0;

    playback_clock_with_triggers i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    function automatic logic signed [31:0] saturate32(longint v);
        if (v > INT32_HI) return 32'sh7FFF_FFFF;
        if (v < INT32_LO) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic int live_slots();
        return (int'(cfg_count) > TRIG_SLOTS) ? TRIG_SLOTS : int'(cfg_count);
    endfunction

    task automatic push_result(logic rkind, logic [15:0] ftype, logic signed [31:0] stime,
                               logic wrap, logic endr, logic is_last);
        pb_result_t r;
        r.rkind   = rkind;
        r.ftype   = ftype;
        r.stime   = stime;
        r.wrap    = wrap;
        r.endr    = endr;
        r.is_last = is_last;
        playback_results.push_back(r);
    endtask

    task automatic find_next_trigger();
        int n;
        n = live_slots();
        walk_valid = 1'b0;
        walk_idx   = '0;
        if (cfg_inverse) begin
            for (int i = n; i > 0; i--) begin
                if (longint'(entry_times[i-1]) < longint'(clk_pos)) begin
                    walk_idx   = 4'(i - 1);
                    walk_valid = 1'b1;
                    return;
                end
            end
        end else begin
            for (int i = 0; i < n; i++) begin
                if (longint'(entry_times[i]) > longint'(clk_pos)) begin
                    walk_idx   = 4'(i);
                    walk_valid = 1'b1;
                    return;
                end
            end
        end
    endtask

    task automatic advance_clock(logic [30:0] tick, output logic wrap, output logic endr);
        longint             prod;
        logic signed [31:0] dt;
        int                 n;
        logic               hit;
        wrap = 1'b0;
        endr = 1'b0;
        hit  = 1'b0;
        n    = live_slots();
        prod = longint'(cfg_speed) * longint'(tick);
        dt   = saturate32(prod >>> 8);
        if (cfg_loop) begin
            if (clk_pos < 0 || longint'(clk_pos) >= longint'(cfg_clip)) begin
                clk_pos = '0;
                find_next_trigger();
                wrap = 1'b1;
            end else begin
                clk_pos = saturate32(longint'(clk_pos) + longint'(dt));
            end
        end else begin
            if (clk_pos < 0) begin
                clk_pos = '0;
                hit     = 1'b1;
            end
            if (longint'(clk_pos) > longint'(cfg_clip)) begin
                clk_pos = saturate32(longint'(cfg_clip) - longint'(dt));
                hit     = 1'b1;
            end
            if (!hit) clk_pos = saturate32(longint'(clk_pos) + longint'(dt));
            endr = hit;
        end
        if (!cfg_inverse) begin
            while (walk_valid && longint'(clk_pos) > longint'(entry_times[walk_idx])) begin
                push_result(RES_TRIGGER, entry_types[walk_idx], clk_pos, 1'b0, 1'b0, 1'b0);
                if (int'(walk_idx) + 1 < n) begin
                    walk_idx = walk_idx + 1'b1;
                end else begin
                    walk_valid = 1'b0;
                    walk_idx   = '0;
                end
            end
        end
    endtask

    task automatic play_item(kind_t kind, logic [30:0] tick, logic signed [31:0] seek,
                             logic [3:0] idx, logic [30:0] etime, logic [15:0] etype);
        logic               wrap;
        logic               endr;
        logic signed [31:0] stime;
        wrap = 1'b0;
        endr = 1'b0;
        case (kind)
            KIND_TICK: begin
                if (cfg_enabled) advance_clock(tick, wrap, endr);
            end
            KIND_SEEK: begin
                if (cfg_enabled) begin
                    if (seek < 0) clk_pos = '0;
                    else if (longint'(seek) > longint'(cfg_clip)) clk_pos = {1'b0, cfg_clip};
                    else clk_pos = seek;
                end
            end
            KIND_RESTART: begin
                clk_pos = '0;
                find_next_trigger();
                if (cfg_enabled) advance_clock('0, wrap, endr);
            end
            default: begin
                entry_times[idx] = etime;
                entry_types[idx] = etype;
            end
        endcase
        stime = cfg_inverse ? saturate32(longint'(cfg_clip) - longint'(clk_pos)) : clk_pos;
        push_result(RES_REPORT, 16'h0000, stime, wrap, endr, 1'b1);
    endtask

    task automatic note_mismatch(string what, longint got, longint want);
        $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        pb_result_t r;
        if (aresetn && m_tvalid && m_tready) begin
            if (playback_results.size() == 0) begin
                note_mismatch("unexpected transfer", longint'(m_tdata[47:16]), longint'(0));
            end else begin
                r = playback_results.pop_front();
                if (m_tuser[0] !== r.rkind)
                    note_mismatch("result_kind", longint'(m_tuser[0]), longint'(r.rkind));
                if (m_tdata[15:0] !== r.ftype)
                    note_mismatch("fired_type", longint'(m_tdata[15:0]), longint'(r.ftype));
                if (m_tdata[47:16] !== r.stime)
                    note_mismatch("sample_time", longint'(m_tdata[47:16]),
                                  longint'(r.stime[31:0]));
                if (m_tdata[48] !== r.wrap)
                    note_mismatch("loop_wrapped", longint'(m_tdata[48]), longint'(r.wrap));
                if (m_tdata[49] !== r.endr)
                    note_mismatch("end_reached", longint'(m_tdata[49]), longint'(r.endr));
                if (m_tlast !== r.is_last)
                    note_mismatch("last", longint'(m_tlast), longint'(r.is_last));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                hang_cycles = 0;
            end else begin
                hang_cycles++;
                if (hang_cycles >= HANG_LIMIT) begin
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // result side backpressure
    initial begin
        bit stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = !quiet_tail && ($urandom_range(0, 3) == 0);
            m_tready <= !stall;
            repeat (stall ? $urandom_range(0, STALL_MAX - 1) : $urandom_range(0, 20))
                @(negedge aclk);
        end
    end

    task automatic send_item(kind_t kind, logic [30:0] tick, logic [31:0] seek,
                             logic [3:0] idx, logic [30:0] etime, logic [15:0] etype);
        if (!quiet_tail && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, STALL_MAX - 1)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, etype, etime, idx, seek, tick};
        do @(posedge aclk); while (!s_tready);
        play_item(kind, tick, seek, idx, etime, etype);
    endtask

    task automatic send_tick(logic [30:0] amount);
        send_item(KIND_TICK, amount, $urandom, 4'($urandom), 31'($urandom), 16'($urandom));
    endtask

    task automatic send_seek(logic [31:0] where);
        send_item(KIND_SEEK, 31'($urandom), where, 4'($urandom), 31'($urandom),
                  16'($urandom));
    endtask

    task automatic send_restart();
        send_item(KIND_RESTART, 31'($urandom), $urandom, 4'($urandom), 31'($urandom),
                  16'($urandom));
    endtask

    task automatic send_entry(logic [3:0] idx, logic [30:0] etime, logic [15:0] etype);
        send_item(KIND_WRITE, 31'($urandom), $urandom, idx, etime, etype);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (playback_results.size() > 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] ridx, logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ridx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (ridx)
            REG_CLIP_LENGTH:   cfg_clip    = val[30:0];
            REG_SPEED:         cfg_speed   = val[15:0];
            REG_LOOP_MODE:     cfg_loop    = val[0];
            REG_INVERSE_MODE:  cfg_inverse = val[0];
            REG_ENABLED:       cfg_enabled = val[0];
            REG_TRIGGER_COUNT: cfg_count   = val[4:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // block must be idle before any register write
    task automatic set_config(logic [30:0] clip, logic [15:0] spd, logic lp, logic inv,
                              logic en, logic [4:0] cnt);
        wait_for_results();
        write_reg(REG_CLIP_LENGTH, {1'b0, clip});
        write_reg(REG_SPEED, {16'h0000, spd});
        write_reg(REG_LOOP_MODE, {31'b0, lp});
        write_reg(REG_INVERSE_MODE, {31'b0, inv});
        write_reg(REG_ENABLED, {31'b0, en});
        write_reg(REG_TRIGGER_COUNT, {27'b0, cnt});
    endtask

    task automatic load_ascending_table(logic [30:0] clip);
        longint t;
        t = 0;
        for (int i = 0; i < TRIG_SLOTS; i++) begin
            t = t + longint'($urandom_range(0, clip / TRIG_SLOTS + 1));
            if (t > INT32_HI) t = INT32_HI;
            send_entry(4'(i), t[30:0], 16'($urandom));
        end
    endtask

    task automatic test_defaults();
        send_tick(31'h0000_8000);
        send_tick(31'h0);
    endtask

    // full table, then walks firing a few triggers and all of them
    task automatic test_trigger_walk();
        for (int i = 0; i < TRIG_SLOTS; i++)
            send_entry(4'(i), 31'((i + 1) * 'h1000),
                       (i == 0) ? 16'h0000 :
                       (i == TRIG_SLOTS - 1) ? 16'hFFFF : 16'(i * 'h0111));
        set_config(31'h2_0000, 16'sd256, 1'b1, 1'b0, 1'b1, 5'd16);
        send_restart();
        send_tick(31'h2800);
        send_restart();
        send_tick(31'h1_8000);
    endtask

    task automatic test_loop_wrap();
        send_tick(31'h1_0000);
        send_tick(31'h100);
        send_tick(31'h1800);
    endtask

    task automatic test_clamp_and_seek();
        set_config(31'h2_0000, 16'sd256, 1'b0, 1'b0, 1'b1, 5'd16);
        send_seek(32'h8000_0000);
        send_seek(32'h7FFF_FFFF);
        send_tick(31'h1000);
        send_tick(31'h400);
        send_seek(32'h0002_0000);
        set_config(31'h2_0000, 16'hFF00, 1'b0, 1'b0, 1'b1, 5'd16);
        send_tick(31'h3_0000);
        send_tick(31'h100);
        set_config(31'h0, 16'sd256, 1'b0, 1'b0, 1'b1, 5'd0);
        send_seek(32'h0000_1234);
    endtask

    task automatic test_inverse();
        set_config(31'h2_0000, 16'hFF00, 1'b1, 1'b1, 1'b1, 5'd16);
        send_seek(32'h0001_8000);
        send_restart();
        send_tick(31'h4000);
        send_tick(31'h4000);
    endtask

    task automatic test_disabled();
        set_config(31'h2_0000, 16'sd256, 1'b1, 1'b0, 1'b0, 5'd16);
        send_tick(31'h4000);
        send_seek(32'h0000_9000);
        send_restart();
    endtask

    task automatic test_saturation();
        set_config(31'h7FFF_FFFF, 16'sh7FFF, 1'b0, 1'b0, 1'b1, 5'd0);
        send_seek(32'h0);
        send_tick(31'h7FFF_FFFF);
        set_config(31'h7FFF_FFFF, 16'sh8000, 1'b0, 1'b1, 1'b1, 5'd0);
        send_seek(32'h0);
        send_tick(31'h7FFF_FFFF);
        send_tick(31'h7FFF_FFFF);
    endtask

    task automatic test_count_overflow();
        set_config(31'h2_0000, 16'sd256, 1'b1, 1'b0, 1'b1, 5'd31);
        send_restart();
        send_tick(31'h1_8000);
    endtask

    task automatic run_random_phase(int items);
        logic [30:0] clip;
        logic [15:0] spd;
        logic [4:0]  cnt;
        int          pick;
        case ($urandom_range(0, 11))
            0:       clip = '0;
            1:       clip = 31'h7FFF_FFFF;
            default: clip = 31'($urandom_range(31'h100, 31'h4_0000));
        endcase
        case ($urandom_range(0, 9))
            0:       spd = 16'h7FFF;
            1:       spd = 16'h8000;
            default: spd = 16'($urandom_range(0, 1023) - 256);
        endcase
        cnt = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(17, 31)) :
                                            5'($urandom_range(0, 16));
        case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 20;
            default: idle_pct = 50;
        endcase
        set_config(clip, spd, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0,
                   $urandom_range(0, 7) != 0, cnt);
        if ($urandom_range(0, 2) == 0) load_ascending_table(clip);
        send_restart();
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                if ($urandom_range(0, 9) == 0) send_tick(31'($urandom));
                else send_tick(31'($urandom_range(0, clip / 6 + 1)));
            end else if (pick < 75) begin
                if ($urandom_range(0, 3) == 0) send_seek($urandom);
                else send_seek($urandom_range(0, clip));
            end else if (pick < 85) begin
                send_restart();
            end else begin
                send_entry(4'($urandom), 31'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 11; ph++) run_random_phase(22);
    endtask

    task automatic test_steady_tail();
        quiet_tail = 1'b1;
        run_random_phase(60);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;

        cfg_clip    = 31'h1_0000;
        cfg_speed   = 16'sd256;
        cfg_loop    = 1'b1;
        cfg_inverse = 1'b0;
        cfg_enabled = 1'b1;
        cfg_count   = '0;
        clk_pos     = '0;
        walk_idx    = '0;
        walk_valid  = 1'b0;
        for (int i = 0; i < TRIG_SLOTS; i++) begin
            entry_times[i] = '0;
            entry_types[i] = '0;
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_defaults();
        test_trigger_walk();
        test_loop_wrap();
        test_clamp_and_seek();
        test_inverse();
        test_disabled();
        test_saturation();
        test_count_overflow();
        test_random();
        test_steady_tail();

        wait_for_results();
        repeat (40) @(posedge aclk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### playback_clock_with_triggers.f
sv/pbclk_pkg.sv
sv/pbclk_regs.sv
sv/pbclk_ctrl.sv
sv/pbclk_dp.sv
sv/playback_clock_with_triggers.sv
sv/pbclk_checker.sv
bench/tb_playback_clock_with_triggers.sv
